// File: design/avs_pkg.sv
package avs_pkg;

  // Widths fixed by the item and register formats
  localparam int TIME_BITS_DEF = 40;
  localparam int DUR_W         = 24;
  localparam int SPEED_W       = 13;
  localparam int SLEEP_W       = 7;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Minimum datapath width: drift scaled by 256 plus sign, and division remainders
  localparam int DRIFT_W = 42;

  // Quotient bits resolved by the divider (one overflow test on top)
  localparam int QUO_W = 8;

  // Register reset values
  localparam logic [DUR_W-1:0]   VIDEO_NOM_RST = 24'd40000;
  localparam logic [DUR_W-1:0]   AUDIO_NOM_RST = 24'd20000;
  localparam logic [SPEED_W-1:0] SPEED_RST     = 13'd256;

  // Speed bands and write filter
  localparam logic [SPEED_W-1:0] SPEED_SLOW_MAX = 13'd204;
  localparam logic [SPEED_W-1:0] SPEED_FAST_MIN = 13'd308;
  localparam logic [SPEED_W-1:0] SPEED_MIN_STEP = 13'd2;

  // Drift thresholds in us
  localparam logic [MUL_B_W-1:0] LAG_US       = 18'd100000;
  localparam logic [MUL_B_W-1:0] SLOW_HI_US   = 18'd50000;
  localparam logic [MUL_B_W-1:0] SLOW_LO_US   = 18'd20000;
  localparam logic [MUL_B_W-1:0] FAST_HI_US   = 18'd150000;
  localparam logic [MUL_B_W-1:0] FAST_LO_US   = 18'd60000;
  localparam logic [MUL_B_W-1:0] NORM_HI_US   = 18'd20000;
  localparam logic [MUL_B_W-1:0] NORM_LO_US   = 18'd10000;

  // Q16 factors, rounded down
  localparam logic [MUL_B_W-1:0] F_ONE  = 18'd65536;
  localparam logic [MUL_B_W-1:0] F_1_5  = 18'd98304;
  localparam logic [MUL_B_W-1:0] F_1_1  = 18'd72089;
  localparam logic [MUL_B_W-1:0] F_0_5  = 18'd32768;
  localparam logic [MUL_B_W-1:0] F_0_9  = 18'd58982;
  localparam logic [MUL_B_W-1:0] F_1_2  = 18'd78643;
  localparam logic [MUL_B_W-1:0] F_1_05 = 18'd68812;
  localparam logic [MUL_B_W-1:0] F_0_8  = 18'd52428;
  localparam logic [MUL_B_W-1:0] F_0_95 = 18'd62259;

  // Divisor scale: 256 (Q8 speed) * 1000 (us to ms)
  localparam logic [MUL_B_W-1:0] DIV_SCALE = 18'd256000;

  // Drift clip limits, 33-bit signed
  localparam logic [32:0] DRIFT_POS_MAX = {1'b0, {32{1'b1}}};
  localparam logic [32:0] DRIFT_NEG_MAX = {1'b1, {32{1'b0}}};

  // Sleep limits in ms
  localparam logic [SLEEP_W-1:0] SLEEP_MIN    = 7'd1;
  localparam logic [SLEEP_W-1:0] SLEEP_MAX    = 7'd100;
  localparam logic [SLEEP_W-1:0] SLEEP_PAUSED = 7'd100;

  typedef enum logic [1:0] {
    REG_VIDEO_NOM = 2'd0,
    REG_AUDIO_NOM = 2'd1,
    REG_SPEED     = 2'd2,
    REG_PAUSED    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0]   video_nom;
    logic [DUR_W-1:0]   audio_nom;
    logic [SPEED_W-1:0] speed;
    logic               paused;
  } cfg_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef enum logic [1:0] {
    BAND_SLOW,
    BAND_NORM,
    BAND_FAST
  } band_t;

  // Drift tests in the order they are tried
  typedef enum logic [2:0] {
    TST_LAG,
    TST_POS_HI,
    TST_POS_LO,
    TST_NEG_HI,
    TST_NEG_LO
  } tst_t;

  function automatic band_t band_of(logic [SPEED_W-1:0] speed);
    band_t b;
    if (speed <= SPEED_SLOW_MAX) begin
      b = BAND_SLOW;
    end else if (speed >= SPEED_FAST_MIN) begin
      b = BAND_FAST;
    end else begin
      b = BAND_NORM;
    end
    return b;
  endfunction

  // Threshold for a test, before scaling by speed
  function automatic logic [MUL_B_W-1:0] thr_us(band_t band, tst_t tst);
    logic hi;
    logic [MUL_B_W-1:0] k;
    hi = (tst == TST_POS_HI) || (tst == TST_NEG_HI);
    k  = LAG_US;
    if (tst != TST_LAG) begin
      case (band)
        BAND_SLOW: k = hi ? SLOW_HI_US : SLOW_LO_US;
        BAND_FAST: k = hi ? FAST_HI_US : FAST_LO_US;
        BAND_NORM: k = hi ? NORM_HI_US : NORM_LO_US;
        default:   k = hi ? NORM_HI_US : NORM_LO_US;
      endcase
    end
    return k;
  endfunction

  // Frame-delay factor picked when a test hits
  function automatic logic [MUL_B_W-1:0] factor(band_t band, tst_t tst);
    logic norm;
    logic [MUL_B_W-1:0] f;
    norm = (band == BAND_NORM);
    case (tst)
      TST_POS_HI: f = norm ? F_1_2  : F_1_5;
      TST_POS_LO: f = norm ? F_1_05 : F_1_1;
      TST_NEG_HI: f = norm ? F_0_8  : F_0_5;
      TST_NEG_LO: f = norm ? F_0_95 : F_0_9;
      default:    f = F_ONE;
    endcase
    return f;
  endfunction

endpackage

// File: design/avs_if.sv
// Update request channel
interface avs_req_if #(
  parameter int TIME_BITS = avs_pkg::TIME_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic signed [TIME_BITS-1:0]      pts_us;
  logic [avs_pkg::DUR_W-1:0]        duration_us;

  modport source (output valid, req_type, pts_us, duration_us, input ready);
  modport sink   (input valid, req_type, pts_us, duration_us, output ready);
endinterface

// Frame sleep result channel
interface avs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [avs_pkg::SLEEP_W-1:0] sleep_ms;

  modport source (output valid, sleep_ms, input ready);
  modport sink   (input valid, sleep_ms, output ready);
endinterface

// File: design/avs_cfg.sv
module avs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [avs_pkg::ADDR_W-1:0]  paddr,
  input  logic [avs_pkg::DATA_W-1:0]  pwdata,
  output logic [avs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output avs_pkg::cfg_t               cfg
);

  logic                         wr_en;
  avs_pkg::reg_idx_t            idx;
  logic [avs_pkg::SPEED_W-1:0]  speed_wr;
  logic [avs_pkg::SPEED_W-1:0]  speed_delta;
  logic                         speed_ok;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = avs_pkg::reg_idx_t'(paddr[avs_pkg::ADDR_W-1:2]);

  // Speed writes of zero or within two steps of the current value are dropped
  assign speed_wr    = pwdata[avs_pkg::SPEED_W-1:0];
  assign speed_delta = (speed_wr > cfg.speed) ? (speed_wr - cfg.speed)
                                              : (cfg.speed - speed_wr);
  assign speed_ok    = (speed_wr != '0) && (speed_delta > avs_pkg::SPEED_MIN_STEP);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.video_nom <= avs_pkg::VIDEO_NOM_RST;
      cfg.audio_nom <= avs_pkg::AUDIO_NOM_RST;
      cfg.speed     <= avs_pkg::SPEED_RST;
      cfg.paused    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        avs_pkg::REG_VIDEO_NOM: cfg.video_nom <= pwdata[avs_pkg::DUR_W-1:0];
        avs_pkg::REG_AUDIO_NOM: cfg.audio_nom <= pwdata[avs_pkg::DUR_W-1:0];
        avs_pkg::REG_SPEED: begin
          if (speed_ok) cfg.speed <= speed_wr;
        end
        avs_pkg::REG_PAUSED:    cfg.paused    <= pwdata[0];
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      avs_pkg::REG_VIDEO_NOM: prdata = avs_pkg::DATA_W'(cfg.video_nom);
      avs_pkg::REG_AUDIO_NOM: prdata = avs_pkg::DATA_W'(cfg.audio_nom);
      avs_pkg::REG_SPEED:     prdata = avs_pkg::DATA_W'(cfg.speed);
      avs_pkg::REG_PAUSED:    prdata = avs_pkg::DATA_W'(cfg.paused);
    endcase
  end

endmodule

// File: design/avs_alu.sv
module avs_alu #(
  parameter int AW = avs_pkg::DRIFT_W
) (
  input  avs_pkg::alu_op_t     op,
  input  logic signed [AW-1:0] a,
  input  logic signed [AW-1:0] b,
  output logic signed [AW-1:0] res,
  output logic                 neg,
  output logic                 zero
);

  // Single add/subtract shared by the clock and drift-test compares, the timestamp sum and the division steps
  always_comb begin
    unique case (op)
      avs_pkg::ALU_ADD: res = a + b;
      avs_pkg::ALU_SUB: res = a - b;
    endcase
  end

  assign neg  = res[AW-1];
  assign zero = (res == '0);

endmodule

// File: design/avs_seq.sv
module avs_seq #(
  parameter int TIME_BITS = avs_pkg::TIME_BITS_DEF,
  parameter int AW        = avs_pkg::DRIFT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  avs_pkg::cfg_t        cfg,
  avs_req_if.sink              req,
  avs_rsp_if.source            rsp,
  output avs_pkg::alu_op_t     alu_op,
  output logic signed [AW-1:0] alu_a,
  output logic signed [AW-1:0] alu_b,
  input  logic signed [AW-1:0] alu_res,
  input  logic                 alu_neg,
  input  logic                 alu_zero
);

  localparam int PW   = TIME_BITS - 1;
  localparam int QI_W = $clog2(avs_pkg::QUO_W + 1);
  localparam logic [PW-1:0]   PTS_MAX = {PW{1'b1}};
  localparam logic [QI_W-1:0] QI_TOP  = QI_W'(avs_pkg::QUO_W);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SUM, S_PTS, S_GE1, S_GE2, S_FIN, S_DRIFT,
    S_TMUL, S_TCMP, S_NMUL, S_DMUL, S_DIV, S_QOUT, S_OUT
  } state_t;

  state_t state;

  // Latched transaction
  logic                          is_video;
  logic signed [TIME_BITS-1:0]   in_pts;
  logic [avs_pkg::DUR_W-1:0]     in_dur;

  // Clock state
  logic [PW-1:0]                 video_pts;
  logic [avs_pkg::DUR_W-1:0]     video_dur;
  logic                          video_valid;
  logic [PW-1:0]                 audio_pts;
  logic [avs_pkg::DUR_W-1:0]     audio_dur;
  logic                          audio_valid;

  // Working registers
  logic [avs_pkg::DUR_W-1:0]     nd;
  logic [PW-1:0]                 sum_sat;
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          dn;
  avs_pkg::tst_t                 tst;
  logic [avs_pkg::MUL_B_W-1:0]   fac;
  logic [avs_pkg::PROD_W-1:0]    prod;
  logic signed [AW-1:0]          rem;
  logic [QI_W-1:0]               bit_i;
  logic [avs_pkg::QUO_W-1:0]     quo;
  logic [avs_pkg::SLEEP_W-1:0]   out_val;
  logic                          rsp_vld;
  logic [avs_pkg::SLEEP_W-1:0]   rsp_sleep;

  // Combinational helpers
  logic [PW-1:0]                 cur_pts;
  logic [avs_pkg::DUR_W-1:0]     cur_dur;
  logic [avs_pkg::DUR_W-1:0]     nom;
  logic [avs_pkg::DUR_W-1:0]     d_prev;
  logic [avs_pkg::DUR_W-1:0]     d_nom;
  logic                          dur_far;
  logic [avs_pkg::DUR_W-1:0]     nd_next;
  logic [PW-1:0]                 p_in;
  logic [PW-1:0]                 sum_sat_next;
  logic [AW-32-1:0]              drift_hi;
  logic [32:0]                   drift_clip;
  logic signed [AW-1:0]          dn_next;
  logic                          both_valid;
  avs_pkg::band_t                band;
  logic signed [AW-1:0]          m;
  logic                          hit;
  logic [avs_pkg::MUL_A_W-1:0]   mul_a;
  logic [avs_pkg::MUL_B_W-1:0]   mul_b;
  logic                          wb_pts_en;
  logic [PW-1:0]                 wb_pts;
  logic                          wb_valid_en;
  logic                          wb_valid;
  logic                          wb_dur_en;

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = rsp_vld;
  assign rsp.sleep_ms = rsp_sleep;

  // Selected clock and duration cleanup
  assign cur_pts = is_video ? video_pts : audio_pts;
  assign cur_dur = is_video ? video_dur : audio_dur;
  assign nom     = is_video ? cfg.video_nom : cfg.audio_nom;
  assign d_prev  = (in_dur > cur_dur) ? (in_dur - cur_dur) : (cur_dur - in_dur);
  assign d_nom   = (in_dur > nom) ? (in_dur - nom) : (nom - in_dur);
  assign dur_far = ({d_prev, 1'b0} >= {1'b0, nom}) || ({d_nom, 1'b0} >= {1'b0, nom});
  assign nd_next = ((in_dur == '0) || dur_far) ? nom : in_dur;

  assign p_in         = in_pts[PW-1:0];
  assign sum_sat_next = acc[PW] ? PTS_MAX : acc[PW-1:0];

  // Drift clipped to about 2^32 us, then scaled by 256
  assign drift_hi   = alu_res[AW-1:32];
  assign drift_clip = ((&drift_hi) || !(|drift_hi)) ? alu_res[32:0]
                    : (alu_res[AW-1] ? avs_pkg::DRIFT_NEG_MAX : avs_pkg::DRIFT_POS_MAX);
  assign dn_next    = {{(AW-41){drift_clip[32]}}, drift_clip, 8'h00};
  assign both_valid = video_valid && audio_valid;

  assign band = avs_pkg::band_of(cfg.speed);
  assign m    = AW'(prod);

  // ALU and multiplier operand selection, clock write-back
  always_comb begin
    alu_op      = avs_pkg::ALU_SUB;
    alu_a       = acc;
    alu_b       = '0;
    hit         = 1'b0;
    mul_a       = avs_pkg::MUL_A_W'(cfg.speed);
    mul_b       = avs_pkg::thr_us(band, tst);
    wb_pts_en   = 1'b0;
    wb_pts      = sum_sat;
    wb_valid_en = 1'b0;
    wb_valid    = 1'b1;
    wb_dur_en   = 1'b0;
    unique case (state)
      S_LOAD: begin
        if (!cfg.paused) begin
          if (nom == '0) begin
            wb_valid_en = 1'b1;
            wb_valid    = 1'b0;
          end else begin
            wb_dur_en = 1'b1;
          end
        end
      end
      S_SUM: begin
        alu_op = avs_pkg::ALU_ADD;
        alu_a  = AW'(cur_pts);
        alu_b  = AW'(nd);
      end
      S_PTS: begin
        alu_a = AW'(p_in);
        alu_b = AW'(cur_pts);
        if (in_pts[TIME_BITS-1]) begin
          wb_pts_en   = 1'b1;
          wb_pts      = sum_sat_next;
          wb_valid_en = 1'b1;
        end else if (in_pts == '0) begin
          wb_pts_en   = 1'b1;
          wb_pts      = '0;
          wb_valid_en = 1'b1;
          wb_valid    = (cur_pts == '0);
        end
      end
      S_GE1: begin
        // 2*(p - last) >= nd
        alu_a = acc <<< 1;
        alu_b = AW'(nd);
        if (!alu_neg) begin
          wb_pts_en   = 1'b1;
          wb_valid_en = 1'b1;
        end
      end
      S_GE2: begin
        // 2*(last - p) >= nd, as 2*(p - last) + nd <= 0
        alu_op    = avs_pkg::ALU_ADD;
        alu_a     = acc <<< 1;
        alu_b     = AW'(nd);
        wb_pts_en = 1'b1;
        if (alu_neg || alu_zero) begin
          wb_valid_en = 1'b1;
        end else begin
          wb_pts = p_in;
        end
      end
      S_DRIFT: begin
        alu_a = AW'(video_pts);
        alu_b = AW'(audio_pts);
      end
      S_TCMP: begin
        unique case (tst)
          avs_pkg::TST_LAG: begin
            alu_op = avs_pkg::ALU_ADD;
            alu_a  = dn;
            alu_b  = m;
            hit    = alu_neg || alu_zero;
          end
          avs_pkg::TST_POS_HI, avs_pkg::TST_POS_LO: begin
            alu_a = m;
            alu_b = dn;
            hit   = alu_neg;
          end
          avs_pkg::TST_NEG_HI, avs_pkg::TST_NEG_LO: begin
            alu_op = avs_pkg::ALU_ADD;
            alu_a  = dn;
            alu_b  = m;
            hit    = alu_neg;
          end
          default: hit = 1'b0;
        endcase
      end
      S_NMUL: begin
        mul_a = cur_dur;
        mul_b = fac;
      end
      S_DMUL: begin
        mul_b = avs_pkg::DIV_SCALE;
      end
      S_DIV: begin
        alu_a = rem;
        alu_b = m << bit_i;
      end
      default: begin
        alu_op = avs_pkg::ALU_SUB;
      end
    endcase
  end

  // Sequencer, clock state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_vld     <= 1'b0;
      video_pts   <= '0;
      video_dur   <= avs_pkg::VIDEO_NOM_RST;
      video_valid <= 1'b0;
      audio_pts   <= '0;
      audio_dur   <= avs_pkg::AUDIO_NOM_RST;
      audio_valid <= 1'b0;
    end else begin
      // Drained result; a reload in S_OUT takes over
      if (rsp_vld && rsp.ready && (state != S_OUT)) rsp_vld <= 1'b0;

      // Write-back to the selected clock
      if (wb_pts_en) begin
        if (is_video) video_pts <= wb_pts;
        else          audio_pts <= wb_pts;
      end
      if (wb_valid_en) begin
        if (is_video) video_valid <= wb_valid;
        else          audio_valid <= wb_valid;
      end
      if (wb_dur_en) begin
        if (is_video) video_dur <= nd_next;
        else          audio_dur <= nd_next;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            is_video <= req.req_type;
            in_pts   <= req.pts_us;
            in_dur   <= req.duration_us;
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          nd <= nd_next;
          if (cfg.paused) begin
            out_val <= avs_pkg::SLEEP_PAUSED;
            state   <= is_video ? S_OUT : S_IDLE;
          end else if (nom == '0) begin
            state <= is_video ? S_DRIFT : S_IDLE;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          acc   <= alu_res;
          state <= S_PTS;
        end
        S_PTS: begin
          sum_sat <= sum_sat_next;
          acc     <= alu_res;
          state   <= (in_pts[TIME_BITS-1] || (in_pts == '0)) ? S_FIN : S_GE1;
        end
        S_GE1: begin
          state <= alu_neg ? S_GE2 : S_FIN;
        end
        S_GE2: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= is_video ? S_DRIFT : S_IDLE;
        end
        S_DRIFT: begin
          dn    <= both_valid ? dn_next : '0;
          tst   <= avs_pkg::TST_LAG;
          state <= S_TMUL;
        end
        S_TMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_TCMP;
        end
        S_TCMP: begin
          if (tst == avs_pkg::TST_LAG) begin
            if (hit) begin
              out_val <= avs_pkg::SLEEP_MIN;
              state   <= S_OUT;
            end else begin
              tst   <= avs_pkg::TST_POS_HI;
              state <= S_TMUL;
            end
          end else if (hit) begin
            fac   <= avs_pkg::factor(band, tst);
            state <= S_NMUL;
          end else if (tst == avs_pkg::TST_NEG_LO) begin
            fac   <= avs_pkg::F_ONE;
            state <= S_NMUL;
          end else begin
            tst   <= avs_pkg::tst_t'(tst + 3'd1);
            state <= S_TMUL;
          end
        end
        S_NMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_DMUL;
        end
        S_DMUL: begin
          rem   <= AW'(prod);
          prod  <= mul_a * mul_b;
          bit_i <= QI_TOP;
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle
          if (bit_i == QI_TOP) begin
            if (!alu_neg) begin
              out_val <= avs_pkg::SLEEP_MAX;
              state   <= S_OUT;
            end else begin
              bit_i <= bit_i - 1'b1;
            end
          end else begin
            quo <= {quo[avs_pkg::QUO_W-2:0], !alu_neg};
            if (!alu_neg) rem <= alu_res;
            if (bit_i == '0) state <= S_QOUT;
            else             bit_i <= bit_i - 1'b1;
          end
        end
        S_QOUT: begin
          if (quo == '0) begin
            out_val <= avs_pkg::SLEEP_MIN;
          end else if (quo > avs_pkg::QUO_W'(avs_pkg::SLEEP_MAX)) begin
            out_val <= avs_pkg::SLEEP_MAX;
          end else begin
            out_val <= quo[avs_pkg::SLEEP_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_vld || rsp.ready) begin
            rsp_vld   <= 1'b1;
            rsp_sleep <= out_val;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/av_sync_frame_delay.sv
// Audio/video sync clock with frame-sleep result on video updates.
// Audio updates keep the block busy and give no result; a paused video update goes from S_LOAD
// to S_OUT; other video updates run up to 5 drift tests and 9 divider steps before S_OUT.
// One transaction at a time on the single shared add/subtract unit and multiplier; after a
// video update, ready again once the sleep value is in the output register.
// Reset (rst, synchronous): clocks invalid, timestamps 0, durations and registers at defaults.
module av_sync_frame_delay #(
  parameter int TIME_BITS = avs_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  avs_req_if.sink                     req,
  avs_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [avs_pkg::ADDR_W-1:0]  paddr,
  input  logic [avs_pkg::DATA_W-1:0]  pwdata,
  output logic [avs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int AW = (TIME_BITS + 2 > avs_pkg::DRIFT_W) ? TIME_BITS + 2 : avs_pkg::DRIFT_W;

  avs_pkg::cfg_t        cfg;
  avs_pkg::alu_op_t     alu_op;
  logic signed [AW-1:0] alu_a;
  logic signed [AW-1:0] alu_b;
  logic signed [AW-1:0] alu_res;
  logic                 alu_neg;
  logic                 alu_zero;

  // Configuration registers
  avs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared add/subtract unit
  avs_alu #(
    .AW (AW)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .neg  (alu_neg),
    .zero (alu_zero)
  );

  // Sequencer and clock state
  avs_seq #(
    .TIME_BITS (TIME_BITS),
    .AW        (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req),
    .rsp      (rsp),
    .alu_op   (alu_op),
    .alu_a    (alu_a),
    .alu_b    (alu_b),
    .alu_res  (alu_res),
    .alu_neg  (alu_neg),
    .alu_zero (alu_zero)
  );

endmodule

// File: design/avs_checker.sv
module avs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [avs_pkg::SLEEP_W-1:0] sleep_ms
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(sleep_ms))
    else $error("result dropped or changed while stalled");

  // Sleep values stay within 1..100 ms
  a_sleep_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (sleep_ms >= avs_pkg::SLEEP_MIN) && (sleep_ms <= avs_pkg::SLEEP_MAX))
    else $error("sleep value out of range");

  // One transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a transaction back to back");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind av_sync_frame_delay avs_checker u_avs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .sleep_ms  (rsp.sleep_ms)
);
